### rtl/core/rgb_to_hsl_converter_macros.svh
// Assertion macros used by the checker file of the RGB to HSL converter.
`ifndef RGB_TO_HSL_CONVERTER_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define RHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsl_converter assertion failed");

// Condition implies consequence in the next cycle.
`define RHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_hsl_converter assertion failed");

`endif

### rtl/core/rhc_pkg.sv
// Shared types and constants of the RGB to HSL converter.
`default_nettype none
package rhc_pkg;
    localparam int ChanW   = 13;          // clamped channel width
    localparam int NumW    = 28;          // dividend width
    localparam int DenW    = 14;          // doubled divisor width
    localparam int QuotW   = 15;          // quotient bits, one pipeline stage each
    localparam logic [ChanW-1:0] ChOne    = 13'd4096;
    localparam logic [QuotW-1:0] HueFull  = 15'd23040;
    localparam logic [12:0]      HueScale = 13'd7680;   // 2 * 60 * 64

    // One classified pixel: two divisions and the finished lightness.
    typedef struct packed {
        logic [NumW-1:0]  sat_num;
        logic [DenW-1:0]  sat_den;
        logic [NumW-1:0]  hue_num;
        logic [DenW-1:0]  hue_den;
        logic [ChanW-1:0] light;
    } t_job;
endpackage
`default_nettype wire

### rtl/core/rhc_front.sv
// Front end: accepts pixels, clamps, finds max and min, and sets up the divisions.
`default_nettype none
module rhc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [15:0]  i_red,
    input  wire logic [15:0]  i_green,
    input  wire logic [15:0]  i_blue,
    output logic              o_valid,
    input  wire logic         i_ready,
    output rhc_pkg::t_job     o_job
);
    logic                    r_valid;
    rhc_pkg::t_job           r_job;
    rhc_pkg::t_job           n_job;
    logic [rhc_pkg::ChanW-1:0] s_r, s_g, s_b, s_mx, s_mn, s_d, s_den;
    logic [rhc_pkg::ChanW:0]   s_sum;
    logic signed [16:0]        s_pos;

    function automatic logic [rhc_pkg::ChanW-1:0] clamp(input logic [15:0] v);
        logic [rhc_pkg::ChanW-1:0] res;
        if (v[15]) begin
            res = '0;
        end else if (v[14:0] > 15'(rhc_pkg::ChOne)) begin
            res = rhc_pkg::ChOne;
        end else begin
            res = v[rhc_pkg::ChanW-1:0];
        end
        return res;
    endfunction

    // Classification and setup of the saturation and hue divisions.
    always_comb begin
        s_r = clamp(i_red);
        s_g = clamp(i_green);
        s_b = clamp(i_blue);
        s_mx = s_r;
        s_mn = s_r;
        if (s_g > s_mx) s_mx = s_g;
        if (s_b > s_mx) s_mx = s_b;
        if (s_g < s_mn) s_mn = s_g;
        if (s_b < s_mn) s_mn = s_b;
        s_sum = {1'b0, s_mx} + {1'b0, s_mn};
        s_d   = s_mx - s_mn;
        s_den = (s_sum <= 14'(rhc_pkg::ChOne)) ? s_sum[rhc_pkg::ChanW-1:0]
                                               : 13'(14'd8192 - s_sum);
        // Blue wins ties over green, green over red.
        if (s_b == s_mx) begin
            s_pos = 17'sd4 * $signed({4'b0, s_d}) + $signed({4'b0, s_r})
                    - $signed({4'b0, s_g});
        end else if (s_g == s_mx) begin
            s_pos = 17'sd2 * $signed({4'b0, s_d}) + $signed({4'b0, s_b})
                    - $signed({4'b0, s_r});
        end else begin
            s_pos = $signed({4'b0, s_g}) - $signed({4'b0, s_b});
            if (s_pos < 0) s_pos = s_pos + 17'sd6 * $signed({4'b0, s_d});
        end
        n_job.light = 13'((s_sum + 14'd1) >> 1);
        if (s_d == '0) begin
            // Gray pixel: zero dividends give zero hue and saturation.
            n_job.sat_num = '0;
            n_job.sat_den = 14'd2;
            n_job.hue_num = '0;
            n_job.hue_den = 14'd2;
        end else begin
            n_job.sat_num = rhc_pkg::NumW'({s_d, 13'd0}) + rhc_pkg::NumW'(s_den);
            n_job.sat_den = {s_den, 1'b0};
            n_job.hue_num = rhc_pkg::NumW'(s_pos[14:0]) * rhc_pkg::NumW'(rhc_pkg::HueScale)
                            + rhc_pkg::NumW'(s_d);
            n_job.hue_den = {s_d, 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    // Output register toward the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;
endmodule
`default_nettype wire

### rtl/core/rhc_queue.sv
// Two-entry queue between the front end and the divider pipeline.
`default_nettype none
module rhc_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  rhc_pkg::t_job i_job,
    output logic          o_valid,
    input  wire logic     i_ready,
    output rhc_pkg::t_job o_job
);
    rhc_pkg::t_job r_mem [0:1];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          s_push;
    logic          s_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign s_push  = i_valid && o_ready;
    assign s_pop   = o_valid && i_ready;
    assign o_job   = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (s_push) r_wr_ptr <= !r_wr_ptr;
            if (s_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(s_push) - 2'(s_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (s_push) r_mem[r_wr_ptr] <= i_job;
    end
endmodule
`default_nettype wire

### rtl/core/rhc_back.sv
// Back end: two pipelined restoring dividers, one quotient bit per stage.
`default_nettype none
module rhc_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  rhc_pkg::t_job     i_job,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [14:0]       o_hue,
    output logic [12:0]       o_saturation,
    output logic [12:0]       o_lightness
);
    localparam int QW = rhc_pkg::QuotW;
    localparam int NW = rhc_pkg::NumW;
    localparam int DW = rhc_pkg::DenW;

    logic          r_v     [0:QW];
    logic [NW-1:0] r_srem  [0:QW];
    logic [DW-1:0] r_sden  [0:QW];
    logic [QW-1:0] r_sq    [0:QW];
    logic [NW-1:0] r_hrem  [0:QW];
    logic [DW-1:0] r_hden  [0:QW];
    logic [QW-1:0] r_hq    [0:QW];
    logic [12:0]   r_light [0:QW];
    logic [NW-1:0] n_srem  [0:QW-1];
    logic [QW-1:0] n_sq    [0:QW-1];
    logic [NW-1:0] n_hrem  [0:QW-1];
    logic [QW-1:0] n_hq    [0:QW-1];
    logic          s_en;

    // The whole pipeline advances unless a finished result is held.
    assign s_en    = !r_v[QW] || i_ready;
    assign o_ready = s_en;

    // One restoring step per stage; stage k decides quotient bit QW-1-k.
    always_comb begin
        logic [DW+QW-1:0] sh_s, sh_h;
        for (int k = 0; k < QW; k++) begin
            sh_s = (DW+QW)'(r_sden[k]) << (QW - 1 - k);
            sh_h = (DW+QW)'(r_hden[k]) << (QW - 1 - k);
            n_srem[k] = r_srem[k];
            n_sq[k]   = r_sq[k];
            n_hrem[k] = r_hrem[k];
            n_hq[k]   = r_hq[k];
            if ((DW+QW)'(r_srem[k]) >= sh_s) begin
                n_srem[k] = NW'((DW+QW)'(r_srem[k]) - sh_s);
                n_sq[k][QW-1-k] = 1'b1;
            end
            if ((DW+QW)'(r_hrem[k]) >= sh_h) begin
                n_hrem[k] = NW'((DW+QW)'(r_hrem[k]) - sh_h);
                n_hq[k][QW-1-k] = 1'b1;
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) r_v[k] <= 1'b0;
        end else if (s_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < QW; k++) r_v[k+1] <= r_v[k];
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_srem[0]  <= i_job.sat_num;
            r_sden[0]  <= i_job.sat_den;
            r_sq[0]    <= '0;
            r_hrem[0]  <= i_job.hue_num;
            r_hden[0]  <= i_job.hue_den;
            r_hq[0]    <= '0;
            r_light[0] <= i_job.light;
            for (int k = 0; k < QW; k++) begin
                r_srem[k+1]  <= n_srem[k];
                r_sden[k+1]  <= r_sden[k];
                r_sq[k+1]    <= n_sq[k];
                r_hrem[k+1]  <= n_hrem[k];
                r_hden[k+1]  <= r_hden[k];
                r_hq[k+1]    <= n_hq[k];
                r_light[k+1] <= r_light[k];
            end
        end
    end

    // A hue that rounds up to a full turn wraps to zero.
    assign o_valid      = r_v[QW];
    assign o_hue        = (r_hq[QW] >= rhc_pkg::HueFull) ? '0 : r_hq[QW];
    assign o_saturation = r_sq[QW][12:0];
    assign o_lightness  = r_light[QW];
endmodule
`default_nettype wire

### rtl/core/rgb_to_hsl_converter.sv
// Top level of the RGB to HSL pixel converter.
// Takes one pixel per transfer and gives one HSL result per pixel, in order. Channels
// are signed Q3.12 clamped to 0..1.0; hue comes in 1/64 degree, saturation and
// lightness in Q1.12, all rounded to nearest. One pixel per clock is sustained while
// the output is not stalled. An input transfer passes through the front register,
// one queue entry, a load stage and fifteen divider stages of one quotient bit each,
// their number set by the 15-bit hue quotient. Output stalls freeze the divider
// pipeline; the front keeps taking pixels until the queue and its register are full.
`default_nettype none
module rgb_to_hsl_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // red[15:0], green[31:16], blue[47:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata    // hue[14:0], saturation[27:15],
                                             // lightness[40:28], zero[47:41]
);
    logic          s_f_valid, s_f_ready, s_q_valid, s_q_ready;
    rhc_pkg::t_job s_f_job, s_q_job;
    logic [14:0]   s_hue;
    logic [12:0]   s_sat, s_light;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[15:0]),
        .i_green (s_axis_tdata[31:16]),
        .i_blue  (s_axis_tdata[47:32]),
        .o_valid (s_f_valid),
        .i_ready (s_f_ready),
        .o_job   (s_f_job)
    );

    rhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_f_valid),
        .o_ready (s_f_ready),
        .i_job   (s_f_job),
        .o_valid (s_q_valid),
        .i_ready (s_q_ready),
        .o_job   (s_q_job)
    );

    rhc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_q_valid),
        .o_ready      (s_q_ready),
        .i_job        (s_q_job),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_hue        (s_hue),
        .o_saturation (s_sat),
        .o_lightness  (s_light)
    );

    assign m_axis_tdata = {7'd0, s_light, s_sat, s_hue};
endmodule
`default_nettype wire

### rtl/core/rhc_checker.sv
// Port-level checker of the RGB to HSL converter and its bind.
`default_nettype none
`include "rgb_to_hsl_converter_macros.svh"
module rhc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [47:0] s_axis_tdata,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    // A held result keeps its data.
    `RHC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // Hue stays below a full turn after wrapping.
    `RHC_ASSERT_NOW(a_hue_range, m_axis_tvalid, m_axis_tdata[14:0] < 15'd23040)
    // Saturation and lightness never exceed 1.0 and the padding is zero.
    `RHC_ASSERT_NOW(a_sl_range, m_axis_tvalid, (m_axis_tdata[27:15] <= 13'd4096) && (m_axis_tdata[40:28] <= 13'd4096) && (m_axis_tdata[47:41] == 7'd0))
    // Zero saturation only comes from a gray pixel, which has zero hue.
    `RHC_ASSERT_NOW(a_gray_hue, m_axis_tvalid && (m_axis_tdata[27:15] == 13'd0), m_axis_tdata[14:0] == 15'd0)
endmodule

bind rgb_to_hsl_converter rhc_checker u_rhc_checker (.*);
`default_nettype wire

### sim/rgb_to_hsl_converter_tb.sv
// Self-checking testbench of the RGB to HSL pixel converter.
`default_nettype none
module rgb_to_hsl_converter_tb;
    localparam int  OneVal    = 4096;
    localparam int  HueFullV  = 23040;
    localparam int  Latency   = 19;
    localparam int  MaxGap    = 17;
    localparam longint CycleLimit = 400000;

    // Lightness in the top bits, hue in the bottom bits, as on the output bus.
    typedef struct packed {
        logic [12:0] light;
        logic [12:0] sat;
        logic [14:0] hue;
    } t_hsl;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // red[15:0], green[31:16], blue[47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // hue[14:0], saturation[27:15], lightness[40:28]

    t_hsl   expected_hsl[$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     rx_stall_on = 1'b1;

    rgb_to_hsl_converter dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Clamp a raw signed channel to 0..1.0.
    function automatic longint clamp_chan(logic [15:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v < 0) v = 0;
        if (v > OneVal) v = OneVal;
        return v;
    endfunction

    function automatic longint round_div(longint num, longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    // Expected HSL of one pixel.
    function automatic t_hsl convert_pixel(logic [15:0] red, logic [15:0] green,
                                           logic [15:0] blue);
        longint r, g, b, mx, mn, sum, d, den, pos, hue;
        t_hsl res;
        r = clamp_chan(red);
        g = clamp_chan(green);
        b = clamp_chan(blue);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        d = mx - mn;
        res.light = 13'((sum + 1) >> 1);
        if (d == 0) begin
            res.sat = '0;
            res.hue = '0;
        end else begin
            den = (sum <= OneVal) ? sum : (2 * OneVal - sum);
            res.sat = 13'(round_div(d << 12, den));
            // Blue wins ties over green, green over red.
            if (b == mx) pos = 4 * d + (r - g);
            else if (g == mx) pos = 2 * d + (b - r);
            else begin
                pos = g - b;
                if (pos < 0) pos += 6 * d;
            end
            hue = round_div(pos * 60 * 64, d);
            while (hue >= HueFullV) hue -= HueFullV;
            res.hue = 15'(hue);
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Send one pixel, with a random gap in front of it.
    task automatic send_pixel(logic [15:0] red, logic [15:0] green, logic [15:0] blue);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MaxGap);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blue, green, red};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_hsl.push_back(convert_pixel(red, green, blue));
    endtask

    // Receiver stall pattern, redrawn per transfer.
    initial begin : rx_stall
        int wait_cycles;
        @(posedge i_clk iff i_rst_n);
        forever begin
            wait_cycles = rx_stall_on ? $urandom_range(0, MaxGap) : 0;
            if ($urandom_range(0, 2) == 0) wait_cycles = 0;
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Compare every output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_hsl got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_hsl'(m_axis_tdata[40:0]);
            if (expected_hsl.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = expected_hsl.pop_front();
                if (got.hue != want.hue) report_mismatch("hue", got.hue, want.hue);
                if (got.sat != want.sat) report_mismatch("saturation", got.sat, want.sat);
                if (got.light != want.light)
                    report_mismatch("lightness", got.light, want.light);
                if (m_axis_tdata[47:41] != '0)
                    report_mismatch("pad bits", m_axis_tdata[47:41], 0);
            end
        end
    end

    task automatic wait_drained();
        while (expected_hsl.size() != 0) @(posedge i_clk);
    endtask

    // Edge values, grays, each dominant channel, ties and out-of-range channels.
    task automatic test_directed();
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'd4096, 16'd4096, 16'd4096);
        send_pixel(16'd2048, 16'd2048, 16'd2048);
        send_pixel(16'h8000, 16'h7FFF, 16'hFFFF);
        send_pixel(16'h7FFF, 16'h8000, 16'h0000);
        send_pixel(16'd4096, 16'd0, 16'd0);
        send_pixel(16'd0, 16'd4096, 16'd0);
        send_pixel(16'd0, 16'd0, 16'd4096);
        send_pixel(16'd4096, 16'd4096, 16'd0);
        send_pixel(16'd0, 16'd4096, 16'd4096);
        send_pixel(16'd4096, 16'd0, 16'd4096);
        send_pixel(16'd4096, 16'd0, 16'd1);
        send_pixel(16'd4096, 16'd1, 16'd0);
        send_pixel(16'd3000, 16'd1000, 16'd2000);
        send_pixel(16'd1000, 16'd3000, 16'd2000);
        send_pixel(16'd1000, 16'd2000, 16'd3000);
        send_pixel(16'd4095, 16'd4096, 16'd4095);
        send_pixel(16'd1, 16'd0, 16'd0);
        send_pixel(16'd2048, 16'd2049, 16'd2047);
        send_pixel(16'hFFFF, 16'd5000, 16'd100);
        send_pixel(16'hAAAA, 16'h5555, 16'h1234);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(4090, 4096));
            2: return 16'($urandom_range(0, 6));
            default: return 16'($urandom_range(0, 4096));
        endcase
    endfunction

    task automatic test_random(int count);
        logic [15:0] r, g, b;
        repeat (count) begin
            r = rand_chan();
            g = rand_chan();
            b = ($urandom_range(0, 7) == 0) ? g : rand_chan();
            send_pixel(r, g, b);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Back-to-back input with the receiver always ready.
    task automatic test_full_rate(int count);
        rx_stall_on = 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rand_chan(), rand_chan(), rand_chan()};
        repeat (count) begin
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            expected_hsl.push_back(convert_pixel(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                                 s_axis_tdata[47:32]));
            s_axis_tdata <= {rand_chan(), rand_chan(), rand_chan()};
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        rx_stall_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        wait_drained();
        test_random(900);
        test_full_rate(300);
        test_random(700);
        wait_drained();
        repeat (Latency + 10) @(posedge i_clk);
        if (error_count == 0 && expected_hsl.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/rhc_pkg.sv
rtl/core/rhc_front.sv
rtl/core/rhc_queue.sv
rtl/core/rhc_back.sv
rtl/core/rgb_to_hsl_converter.sv
rtl/core/rhc_checker.sv
sim/rgb_to_hsl_converter_tb.sv
